>>> rtl/core/assert_macros.svh
// Assertion macros used by key_set_membership.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif

`endif

>>> rtl/core/ksm_pkg.sv
`default_nettype none

package ksm_pkg;

  localparam int unsigned CAPACITY  = 4096;
  localparam int unsigned SLOT_W    = $clog2(CAPACITY);
  localparam int unsigned KEY_W     = 32;
  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_e;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
  } slot_t;

  // Folds the high half of the hash product into the low half and keeps the slot bits.
  function automatic logic [SLOT_W-1:0] fold_slot(input logic [31:0] prod);
    logic [31:0] h;
    h = prod ^ (prod >> 16);
    return h[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/key_set_membership.sv
// A set of 32-bit keys held in a hashed table of 4096 slots with linear probing, kept in one
// synchronous single-port memory. Each transfer on the slave side carries a key in tdata and
// a command in tuser (0 inserts, 1 queries) and yields one transfer on the master side that
// reports whether the key was present before, and for an insert of a new key into a full
// table, that it was dropped. Items are handled one at a time: after an input transfer the
// block accepts no further input until it has hashed the key and probed its slots, at least
// one and at most 4096 of them, as the memory delivers one slot per cycle. A finished
// result waits in an output register, so the next item is accepted while it is still pending;
// an item whose probe ends while that register still holds an untaken result waits until the
// master side takes it. After reset the block clears all 4096 table slots and accepts no
// item until that pass is done.
`default_nettype none

`include "assert_macros.svh"

module key_set_membership import ksm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // key
  input  wire logic        s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // present, table_full, six zero bits
);

  slot_t mem_q [CAPACITY];
  slot_t rd_q;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] probe_q, probe_d;
  logic [31:0]       key_q, key_d;
  cmd_e              cmd_q, cmd_d;
  logic [31:0]       prod_q, prod_d;

  logic              out_valid_q, out_valid_d;
  logic              out_present_q, out_present_d;
  logic              out_full_q, out_full_d;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  slot_t             wr_data;

  logic              hit, empty, last, finish, out_free;

  assign hit      = rd_q.used && (rd_q.key == key_q);
  assign empty    = !rd_q.used;
  assign last     = (probe_q == SLOT_W'(CAPACITY - 1));
  assign finish   = hit || empty || last;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_full_q, out_present_q};

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    pos_d         = pos_q;
    probe_d       = probe_q;
    key_d         = key_q;
    cmd_d         = cmd_q;
    prod_d        = prod_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_present_d = out_present_q;
    out_full_d    = out_full_q;
    rd_en         = 1'b0;
    rd_addr       = pos_q;
    wr_en         = 1'b0;
    wr_addr       = clr_q;
    wr_data       = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          key_d   = s_axis_tdata;
          cmd_d   = cmd_e'(s_axis_tuser);
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        prod_d  = key_q * HASH_MULT;
        state_d = S_READ;
      end
      S_READ: begin
        pos_d   = fold_slot(prod_q);
        probe_d = '0;
        rd_en   = 1'b1;
        rd_addr = fold_slot(prod_q);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!finish) begin
          pos_d   = pos_q + SLOT_W'(1);
          probe_d = probe_q + SLOT_W'(1);
          rd_en   = 1'b1;
          rd_addr = pos_q + SLOT_W'(1);
        end else if (out_free) begin
          out_valid_d   = 1'b1;
          out_present_d = hit;
          out_full_d    = (cmd_q == CMD_INSERT) && !hit && !empty;
          if ((cmd_q == CMD_INSERT) && empty) begin
            wr_en   = 1'b1;
            wr_addr = pos_q;
            wr_data = '{used: 1'b1, key: key_q};
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    probe_q       <= probe_d;
    key_q         <= key_d;
    cmd_q         <= cmd_d;
    prod_q        <= prod_d;
    out_present_q <= out_present_d;
    out_full_q    <= out_full_d;
  end

  `ASSERT_CLK(a_insert_into_empty, clk_i, rst_ni,
              (wr_en && (state_q == S_CHECK)) |-> (empty && (cmd_q == CMD_INSERT)),
              "insert writes a slot that is not empty")
  `ASSERT_CLK(a_full_excludes_present, clk_i, rst_ni,
              m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]),
              "result reports both present and table full")
  `ASSERT_NEXT(a_clear_ends, clk_i, rst_ni,
               (state_q == S_CLEAR) && (clr_q == SLOT_W'(CAPACITY - 1)),
               state_q == S_IDLE, "clearing pass does not end in idle")
  `ASSERT_NEXT(a_probe_advances, clk_i, rst_ni,
               (state_q == S_CHECK) && !finish,
               (state_q == S_CHECK) && (probe_q == $past(probe_q) + SLOT_W'(1)),
               "probe does not advance by one slot")

endmodule

`default_nettype wire

>>> sim/key_set_membership_test.sv
`timescale 1ns / 1ps

module key_set_membership_test;
  import ksm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1580;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned CALM_FROM    = 6000;
  localparam int unsigned CALM_TO      = 9000;
  localparam int unsigned SETTLE       = 20;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] key;
  } request_t;

  typedef struct packed {
    logic present;
    logic table_full;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // key
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // present, table_full, six zero bits

  request_t    request_q[$];
  answer_t     awaited_answers[$];

  // Keys the stimulus has already queued as inserts, used to aim duplicates and hits.
  bit          issued_keys[logic [31:0]];
  logic [31:0] issued_list[$];

  // Predicted contents of the table.
  bit          member_keys[logic [31:0]];
  int unsigned member_count = 0;

  int unsigned cycle_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned inserts_seen = 0;
  int unsigned queries_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned drops_seen = 0;

  logic [31:0] corner_keys[8] = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hDEAD_BEEF};

  key_set_membership i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit calm();
    return cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO;
  endfunction

  function automatic answer_t predict_answer(cmd_e cmd, logic [31:0] key);
    answer_t ans;
    ans.present    = member_keys.exists(key);
    ans.table_full = 1'b0;
    if (cmd == CMD_INSERT) begin
      inserts_seen++;
      if (!ans.present) begin
        if (member_count >= CAPACITY) begin
          ans.table_full = 1'b1;
          drops_seen++;
        end else begin
          member_keys[key] = 1'b1;
          member_count++;
        end
      end
    end else begin
      queries_seen++;
    end
    if (ans.present) hits_seen++;
    return ans;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  function automatic void queue_request(cmd_e cmd, logic [31:0] key);
    request_t req;
    req.cmd = cmd;
    req.key = key;
    request_q = {request_q, req};
    if (cmd == CMD_INSERT && !issued_keys.exists(key) && issued_list.size() < CAPACITY) begin
      issued_keys[key] = 1'b1;
      issued_list = {issued_list, key};
    end
  endfunction

  function automatic logic [31:0] known_key();
    return issued_list[$urandom_range(issued_list.size() - 1)];
  endfunction

  task automatic wait_drained();
    while (request_q.size() != 0 || s_axis_tvalid || awaited_answers.size() != 0)
      @(negedge clk_i);
  endtask

  // Sender side.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t next_req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (request_q.size() != 0 && (calm() || $urandom_range(99) >= 8)) begin
        next_req = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_req.key;
        s_axis_tuser  <= next_req.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side, prediction and checking.
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      m_axis_tready <= calm() || $urandom_range(99) >= 8;
      if (s_axis_tvalid && s_axis_tready)
        awaited_answers = {awaited_answers,
                           predict_answer(cmd_e'(s_axis_tuser), s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (awaited_answers.size() == 0) begin
          flag_mismatch($sformatf("result 0x%02h with no item outstanding", m_axis_tdata));
        end else begin
          want = awaited_answers.pop_front();
          if (m_axis_tdata[0] !== want.present)
            flag_mismatch($sformatf("present expected %0b got %0b",
                                    want.present, m_axis_tdata[0]));
          if (m_axis_tdata[1] !== want.table_full)
            flag_mismatch($sformatf("table_full expected %0b got %0b",
                                    want.table_full, m_axis_tdata[1]));
          if (m_axis_tdata[7:2] !== 6'd0)
            flag_mismatch($sformatf("padding expected 0 got 0x%02h", m_axis_tdata[7:2]));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned sel;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, duplicates and the extreme key patterns.
    queue_request(CMD_QUERY, corner_keys[0]);
    queue_request(CMD_INSERT, corner_keys[0]);
    queue_request(CMD_INSERT, corner_keys[0]);
    for (int i = 1; i < 7; i++) queue_request(CMD_INSERT, corner_keys[i]);
    for (int i = 0; i < 8; i++) queue_request(CMD_QUERY, corner_keys[i]);
    queue_request(CMD_INSERT, corner_keys[1]);
    queue_request(CMD_INSERT, corner_keys[2]);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(99);
      if (sel < 45 && issued_list.size() != 0)
        queue_request(cmd_e'($urandom_range(1)), known_key());
      else if (sel < 55)
        queue_request(cmd_e'($urandom_range(1)), corner_keys[$urandom_range(7)]);
      else
        queue_request(cmd_e'($urandom_range(1)), $urandom());
    end
    // The test waits here until every queued request is sent and every outstanding result is back.
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);

    $display("sent %0d inserts and %0d queries; %0d keys found present, %0d inserts dropped",
             inserts_seen, queries_seen, hits_seen, drops_seen);
    $display("table filled to %0d of %0d slots; %0d results checked, %0d mismatches",
             member_count, CAPACITY, results_checked, mismatches);
    if (mismatches == 0 && awaited_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
